[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[design/mgsp_pkg.sv]
package mgsp_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [1:0] METRIC_EUCLID = 2'd0;
    localparam logic [1:0] METRIC_HYPER  = 2'd1;
    localparam logic [1:0] METRIC_SPHERE = 2'd2;

    typedef struct packed {
        logic vld;
        logic neg;
    } t_div_ctl;

endpackage

[design/mgsp_div.sv]
module mgsp_div import mgsp_pkg::*; #(
    parameter int NW = 81,
    parameter int DW = 64,
    parameter int QB = 32,
    parameter int PW = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_div_ctl             i_ctl,
    input  logic [NW-1:0]        i_num,
    input  logic [DW-1:0]        i_den,
    input  logic [PW-1:0]        i_pay,
    output logic                 o_vld,
    output logic signed [QB-1:0] o_quo,
    output logic [PW-1:0]        o_pay
);

    localparam int XW = (NW > DW + QB) ? NW : DW + QB;

    logic          r_vld [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];
    logic [XW-1:0] r_rem [QB+1];
    logic [DW-1:0] r_den [QB+1];
    logic [QB-1:0] r_quo [QB+1];
    logic [PW-1:0] r_pay [QB+1];

    logic                 r_out_vld;
    logic signed [QB-1:0] r_out_quo;
    logic [PW-1:0]        r_out_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_ctl.neg;
            r_ovf[0] <= 1'b0;
            r_rem[0] <= XW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_pay[0] <= i_pay;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k <= QB; k++) begin : g_stage
        localparam int SH = QB - k;
        logic [XW-1:0] dsh;
        logic          ge;
        logic          ovf;

        always_comb begin
            dsh = XW'(r_den[k-1]) << SH;
            ge  = (r_rem[k-1] >= dsh);
            if (k == 1) begin
                ovf = (r_rem[k-1] >= (XW'(r_den[k-1]) << QB));
            end else begin
                ovf = r_ovf[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= ovf;
                r_rem[k] <= ge ? (r_rem[k-1] - dsh) : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_quo[k] <= r_quo[k-1] | (ge ? (QB'(1) << SH) : '0);
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    logic          rnd;
    logic [QB:0]   qm;
    logic [QB:0]   lim;
    logic [QB:0]   qs;
    logic [QB-1:0] n_quo;

    // Round half away from zero on the magnitude, then clamp to the signed range.
    always_comb begin
        rnd   = ({r_rem[QB], 1'b0} >= (XW+1)'(r_den[QB]));
        qm    = {1'b0, r_quo[QB]} + (QB+1)'(rnd);
        lim   = ((QB+1)'(1) << (QB - 1)) - (QB+1)'(!r_neg[QB]);
        qs    = (r_ovf[QB] || (qm > lim)) ? lim : qm;
        n_quo = r_neg[QB] ? (QB'(0) - qs[QB-1:0]) : qs[QB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_quo <= $signed(n_quo);
            r_out_pay <= r_pay[QB];
        end
    end

    assign o_vld = r_out_vld;
    assign o_quo = r_out_quo;
    assign o_pay = r_out_pay;

endmodule

[design/metric_gram_schmidt_project_core.sv]
// Channel  | Direction | Handshake                  | Beat
// input    | in        | i_in_valid / o_in_stall    | base and vector, four coordinates each
// output   | out       | o_out_valid / i_out_stall  | projected vector and invalid_base flag
// config   | in        | i_cfg_valid / o_cfg_ready  | metric_space, two bits
//
// One beat is accepted per cycle unless o_in_stall is high. The pipeline has
// 2*COORD_WIDTH + 10 register stages. Three dividers of COORD_WIDTH + 2 stages each
// make up most of them: the two dot products side by side, then the quotient.
// Reset is synchronous and clears all valid bits and the metric to euclidean.
// The whole pipeline holds only while a valid result waits on a stalled output.
`include "assert_macros.svh"

module metric_gram_schmidt_project_core import mgsp_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_base_x,
    input  logic signed [COORD_WIDTH-1:0] i_base_y,
    input  logic signed [COORD_WIDTH-1:0] i_base_z,
    input  logic signed [COORD_WIDTH-1:0] i_base_w,
    input  logic signed [COORD_WIDTH-1:0] i_vec_x,
    input  logic signed [COORD_WIDTH-1:0] i_vec_y,
    input  logic signed [COORD_WIDTH-1:0] i_vec_z,
    input  logic signed [COORD_WIDTH-1:0] i_vec_w,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic signed [COORD_WIDTH-1:0] o_out_w,
    output logic                          o_invalid_base
);

    localparam int W   = COORD_WIDTH;
    localparam int PW2 = 2 * W;
    localparam int SW  = 2 * W + 2;
    localparam int DNW = 2 * W + FRAC_BITS + 1;
    localparam int QNW = W + FRAC_BITS;

    logic [1:0] r_metric;
    logic       en;

    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= METRIC_EUCLID;
        end else if (i_cfg_valid) begin
            r_metric <= i_cfg_data;
        end
    end

    // Stage 1: input register.
    logic                r1_vld;
    logic signed [W-1:0] r1_b [4];
    logic signed [W-1:0] r1_v [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_b[0] <= i_base_x;
            r1_b[1] <= i_base_y;
            r1_b[2] <= i_base_z;
            r1_b[3] <= i_base_w;
            r1_v[0] <= i_vec_x;
            r1_v[1] <= i_vec_y;
            r1_v[2] <= i_vec_z;
            r1_v[3] <= i_vec_w;
        end
    end

    // Stage 2: the eight coordinate products.
    logic                  r2_vld;
    logic signed [W-1:0]   r2_b [4];
    logic signed [W-1:0]   r2_v [4];
    logic signed [PW2-1:0] r2_pd [4];
    logic signed [PW2-1:0] r2_pe [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r2_b[k]  <= r1_b[k];
                r2_v[k]  <= r1_v[k];
                r2_pd[k] <= PW2'(r1_b[k]) * PW2'(r1_v[k]);
                r2_pe[k] <= PW2'(r1_b[k]) * PW2'(r1_b[k]);
            end
        end
    end

    // Stage 3: metric sums. Index 0 is <b,v>, index 1 is <b,b>.
    logic                  r3_vld;
    logic signed [W-1:0]   r3_b [4];
    logic signed [W-1:0]   r3_v [4];
    logic signed [SW-1:0]  r3_s [2];
    logic signed [PW2-1:0] r3_w [2];
    logic                  r3_euc;
    logic signed [SW-1:0]  n3_s [2];
    logic signed [SW-1:0]  n3_wt [2];

    always_comb begin
        n3_wt[0] = SW'(r2_pd[3]);
        n3_wt[1] = SW'(r2_pe[3]);
        for (int j = 0; j < 2; j++) begin
            case (r_metric)
                METRIC_HYPER:  n3_wt[j] = -n3_wt[j];
                METRIC_SPHERE: n3_wt[j] = n3_wt[j];
                default:       n3_wt[j] = '0;
            endcase
        end
        n3_s[0] = SW'(r2_pd[0]) + SW'(r2_pd[1]) + SW'(r2_pd[2]) + n3_wt[0];
        n3_s[1] = SW'(r2_pe[0]) + SW'(r2_pe[1]) + SW'(r2_pe[2]) + n3_wt[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_b   <= r2_b;
            r3_v   <= r2_v;
            r3_s   <= n3_s;
            r3_w[0] <= r2_pd[3];
            r3_w[1] <= r2_pe[3];
            r3_euc <= (r_metric != METRIC_HYPER) && (r_metric != METRIC_SPHERE);
        end
    end

    // Divider operands: euclidean divides by the w product unless it is zero or one.
    t_div_ctl         dot_ctl [2];
    logic [DNW-1:0]   dot_num [2];
    logic [PW2-1:0]   dot_den [2];
    logic [SW-1:0]    s_mag [2];
    logic [PW2-1:0]   w_mag [2];
    logic             w_div [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            s_mag[j] = r3_s[j][SW-1] ? (SW'(0) - SW'(r3_s[j])) : SW'(r3_s[j]);
            w_mag[j] = r3_w[j][PW2-1] ? (PW2'(0) - PW2'(r3_w[j])) : PW2'(r3_w[j]);
            w_div[j] = r3_euc && (r3_w[j] != '0)
                       && (SW'(r3_w[j]) != (SW'(1) << (2 * FRAC_BITS)));
            dot_ctl[j].vld = r3_vld;
            if (w_div[j]) begin
                dot_num[j]     = DNW'(s_mag[j]) << FRAC_BITS;
                dot_den[j]     = w_mag[j];
                dot_ctl[j].neg = (r3_s[j] != '0) && (r3_s[j][SW-1] ^ r3_w[j][PW2-1]);
            end else begin
                dot_num[j]     = DNW'(s_mag[j]);
                dot_den[j]     = PW2'(1) << FRAC_BITS;
                dot_ctl[j].neg = r3_s[j][SW-1];
            end
        end
    end

    logic                  d_vld;
    logic                  e_vld;
    logic signed [W-1:0]   d_quo;
    logic signed [W-1:0]   e_quo;
    logic [4*W-1:0]        d_pay;
    logic [4*W-1:0]        e_pay;

    mgsp_div #(.NW(DNW), .DW(PW2), .QB(W), .PW(4 * W)) u_div_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (dot_ctl[0]),
        .i_num   (dot_num[0]),
        .i_den   (dot_den[0]),
        .i_pay   ({r3_v[3], r3_v[2], r3_v[1], r3_v[0]}),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_pay   (d_pay)
    );

    mgsp_div #(.NW(DNW), .DW(PW2), .QB(W), .PW(4 * W)) u_div_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (dot_ctl[1]),
        .i_num   (dot_num[1]),
        .i_den   (dot_den[1]),
        .i_pay   ({r3_b[3], r3_b[2], r3_b[1], r3_b[0]}),
        .o_vld   (e_vld),
        .o_quo   (e_quo),
        .o_pay   (e_pay)
    );

    // Quotient q = d / e, with a zero self-dot taken as one and flagged.
    t_div_ctl        q_ctl;
    logic [QNW-1:0]  q_num;
    logic [W:0]      q_den;
    logic            e_zero;
    logic [W-1:0]    d_mag;
    logic [W-1:0]    e_mag;

    always_comb begin
        e_zero    = (e_quo == '0);
        d_mag     = d_quo[W-1] ? (W'(0) - W'(d_quo)) : W'(d_quo);
        e_mag     = e_quo[W-1] ? (W'(0) - W'(e_quo)) : W'(e_quo);
        q_num     = QNW'(d_mag) << FRAC_BITS;
        q_den     = e_zero ? ((W+1)'(1) << FRAC_BITS) : (W+1)'(e_mag);
        q_ctl.vld = d_vld && e_vld;
        q_ctl.neg = d_quo[W-1] ^ (e_quo[W-1] && !e_zero);
    end

    logic                q_vld;
    logic signed [W-1:0] q_quo;
    logic [8*W:0]        q_pay;

    mgsp_div #(.NW(QNW), .DW(W + 1), .QB(W), .PW(8 * W + 1)) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (q_ctl),
        .i_num   (q_num),
        .i_den   (q_den),
        .i_pay   ({e_zero, e_pay, d_pay}),
        .o_vld   (q_vld),
        .o_quo   (q_quo),
        .o_pay   (q_pay)
    );

    // Stage 6: q times each base coordinate.
    logic                  r6_vld;
    logic                  r6_flag;
    logic signed [W-1:0]   r6_v [4];
    logic signed [PW2-1:0] r6_p [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_flag <= q_pay[8*W];
            for (int k = 0; k < 4; k++) begin
                r6_v[k] <= $signed(q_pay[k*W +: W]);
                r6_p[k] <= PW2'(q_quo) * PW2'($signed(q_pay[(4+k)*W +: W]));
            end
        end
    end

    // Stage 7: drop 16 fraction bits, rounding half away from zero, and clamp.
    localparam int RW = PW2 - FRAC_BITS + 1;

    logic                r7_vld;
    logic                r7_flag;
    logic signed [W-1:0] r7_v [4];
    logic signed [W-1:0] r7_t [4];
    logic [PW2-1:0]      p_mag [4];
    logic [RW-1:0]       p_rnd [4];
    logic [RW-1:0]       p_lim [4];
    logic [RW-1:0]       p_sat [4];
    logic [W-1:0]        n7_t [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p_mag[k] = r6_p[k][PW2-1] ? (PW2'(0) - PW2'(r6_p[k])) : PW2'(r6_p[k]);
            p_rnd[k] = RW'((RW + FRAC_BITS)'(p_mag[k])
                           + ((RW + FRAC_BITS)'(1) << (FRAC_BITS - 1)) >> FRAC_BITS);
            p_lim[k] = (RW'(1) << (W - 1)) - RW'(!r6_p[k][PW2-1]);
            p_sat[k] = (p_rnd[k] > p_lim[k]) ? p_lim[k] : p_rnd[k];
            n7_t[k]  = r6_p[k][PW2-1] ? (W'(0) - p_sat[k][W-1:0]) : p_sat[k][W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_flag <= r6_flag;
            r7_v    <= r6_v;
            for (int k = 0; k < 4; k++) begin
                r7_t[k] <= $signed(n7_t[k]);
            end
        end
    end

    // Stage 8: v - t, clamped, into the output register.
    logic                r_out_vld;
    logic                r_out_flag;
    logic signed [W-1:0] r_out [4];
    logic signed [W:0]   diff [4];
    logic signed [W-1:0] n_out [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            diff[k] = (W+1)'(r7_v[k]) - (W+1)'(r7_t[k]);
            if (diff[k][W] != diff[k][W-1]) begin
                n_out[k] = diff[k][W] ? $signed({1'b1, {(W-1){1'b0}}})
                                      : $signed({1'b0, {(W-1){1'b1}}});
            end else begin
                n_out[k] = $signed(diff[k][W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_flag <= r7_flag;
            r_out      <= n_out;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_out_x        = r_out[0];
    assign o_out_y        = r_out[1];
    assign o_out_z        = r_out[2];
    assign o_out_w        = r_out[3];
    assign o_invalid_base = r_out_flag;

    `ASSERT_CLK(a_stall_only_on_held_out, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled without a held result")
    `ASSERT_CLK(a_accept_enters_pipe, (i_in_valid && !o_in_stall) |=> r1_vld, "accepted beat did not enter stage one")
    `ASSERT_CLK(a_dividers_aligned, d_vld == e_vld, "dot product dividers out of step")
    `ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
